// File: src/xcpd_pkg.sv
// ----------------------------------------------------------------------------
// xcpd_pkg
// Shared types and constants for the xor checked packet deframer.
// ----------------------------------------------------------------------------
package xcpd_pkg;

    typedef enum logic [2:0] {
        ST_HEAD_A = 3'd0,
        ST_HEAD_B = 3'd1,
        ST_TYPE   = 3'd2,
        ST_LENGTH = 3'd3,
        ST_DATA   = 3'd4,
        ST_CHECK  = 3'd5,
        ST_CR     = 3'd6,
        ST_LF     = 3'd7
    } t_frame_state;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_ACCEPT = 3'd1,
        EV_LONG   = 3'd2,
        EV_CHECK  = 3'd3,
        EV_CR     = 3'd4,
        EV_LF     = 3'd5
    } t_event;

    // register select: bit 2 of the byte address
    localparam logic REG_RELAY_ENABLE = 1'b0;
    localparam logic REG_MAX_LENGTH   = 1'b1;

    localparam logic [7:0] C_HEADER           = 8'h24;
    localparam logic [7:0] C_CR               = 8'h0d;
    localparam logic [7:0] C_LF               = 8'h0a;
    localparam logic [7:0] C_MAX_LENGTH_RESET = 8'd201;

    typedef struct packed {
        logic       relay_enable;
        logic [7:0] max_length;
    } t_cfg;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] frame_type;
        logic [7:0] packet_length;
        logic [7:0] computed_checksum;
        logic [7:0] offending_byte;
        logic       relay_valid;
        logic [7:0] relay_data;
    } t_result;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_wr_req;

endpackage

// File: src/xcpd_ram.sv
// ----------------------------------------------------------------------------
// xcpd_ram
// Generic single port ram with registered read data.
// ----------------------------------------------------------------------------
module xcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/xcpd_parser.sv
// ----------------------------------------------------------------------------
// xcpd_parser
// Frame state machine: header search, type, length, payload, checksum, footer.
// ----------------------------------------------------------------------------
module xcpd_parser #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_mode,
    input  logic [7:0]                      i_rx_byte,
    input  xcpd_pkg::t_cfg                  i_cfg,
    output xcpd_pkg::t_result               o_result,
    output xcpd_pkg::t_wr_req               o_wr_req,
    output logic [$clog2(BUFFER_DEPTH)-1:0] o_wr_addr
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    xcpd_pkg::t_frame_state r_state, n_state;
    logic [7:0] r_type, n_type;
    logic [7:0] r_length, n_length;
    logic [7:0] r_count, n_count;
    logic [7:0] r_csum, n_csum;
    xcpd_pkg::t_event ev;
    logic [7:0] offend;
    logic [7:0] count_inc;
    logic       count_in_range;

    assign count_inc      = 8'(r_count + 8'd1);
    assign count_in_range = {1'b0, r_count} < 9'(BUFFER_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= xcpd_pkg::ST_HEAD_A;
            r_type   <= 8'd0;
            r_length <= 8'd0;
            r_count  <= 8'd0;
            r_csum   <= 8'd0;
        end else if (i_accept && !i_mode) begin
            r_state  <= n_state;
            r_type   <= n_type;
            r_length <= n_length;
            r_count  <= n_count;
            r_csum   <= n_csum;
        end
    end

    // next state
    always_comb begin
        unique case (r_state)
            xcpd_pkg::ST_HEAD_A: begin
                n_state = (i_rx_byte == xcpd_pkg::C_HEADER) ? xcpd_pkg::ST_HEAD_B
                                                            : xcpd_pkg::ST_HEAD_A;
            end
            xcpd_pkg::ST_HEAD_B: begin
                n_state = (i_rx_byte == xcpd_pkg::C_HEADER) ? xcpd_pkg::ST_TYPE
                                                            : xcpd_pkg::ST_HEAD_A;
            end
            xcpd_pkg::ST_TYPE: begin
                n_state = xcpd_pkg::ST_LENGTH;
            end
            xcpd_pkg::ST_LENGTH: begin
                if (i_rx_byte == 8'd0) begin
                    n_state = xcpd_pkg::ST_CHECK;
                end else if (i_rx_byte <= i_cfg.max_length) begin
                    n_state = xcpd_pkg::ST_DATA;
                end else begin
                    n_state = xcpd_pkg::ST_HEAD_A;
                end
            end
            xcpd_pkg::ST_DATA: begin
                n_state = (count_inc == r_length) ? xcpd_pkg::ST_CHECK : xcpd_pkg::ST_DATA;
            end
            xcpd_pkg::ST_CHECK: begin
                n_state = (r_csum == i_rx_byte) ? xcpd_pkg::ST_CR : xcpd_pkg::ST_HEAD_A;
            end
            xcpd_pkg::ST_CR: begin
                n_state = (i_rx_byte == xcpd_pkg::C_CR) ? xcpd_pkg::ST_LF
                                                        : xcpd_pkg::ST_HEAD_A;
            end
            xcpd_pkg::ST_LF: begin
                n_state = xcpd_pkg::ST_HEAD_A;
            end
            default: begin
                n_state = xcpd_pkg::ST_HEAD_A;
            end
        endcase
    end

    // datapath updates, events and the payload write
    always_comb begin
        n_type        = r_type;
        n_length      = r_length;
        n_count       = r_count;
        n_csum        = r_csum;
        ev            = xcpd_pkg::EV_NONE;
        offend        = 8'd0;
        o_wr_req.en   = 1'b0;
        o_wr_req.data = i_rx_byte;
        if (!i_mode) begin
            unique case (r_state)
                xcpd_pkg::ST_TYPE: begin
                    n_type = i_rx_byte;
                end
                xcpd_pkg::ST_LENGTH: begin
                    n_length = i_rx_byte;
                    n_count  = 8'd0;
                    n_csum   = 8'd0;
                    if (i_rx_byte != 8'd0 && i_rx_byte > i_cfg.max_length) begin
                        ev = xcpd_pkg::EV_LONG;
                    end
                end
                xcpd_pkg::ST_DATA: begin
                    n_csum      = r_csum ^ i_rx_byte;
                    n_count     = count_inc;
                    o_wr_req.en = i_accept && count_in_range;
                end
                xcpd_pkg::ST_CHECK: begin
                    if (r_csum != i_rx_byte) begin
                        ev     = xcpd_pkg::EV_CHECK;
                        offend = i_rx_byte;
                    end
                end
                xcpd_pkg::ST_CR: begin
                    if (i_rx_byte != xcpd_pkg::C_CR) begin
                        ev     = xcpd_pkg::EV_CR;
                        offend = i_rx_byte;
                    end
                end
                xcpd_pkg::ST_LF: begin
                    if (i_rx_byte == xcpd_pkg::C_LF) begin
                        ev = xcpd_pkg::EV_ACCEPT;
                    end else begin
                        ev     = xcpd_pkg::EV_LF;
                        offend = i_rx_byte;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_wr_addr     = r_count[AW-1:0];

    assign o_result.event_res         = ev;
    assign o_result.frame_type        = n_type;
    assign o_result.packet_length     = n_length;
    assign o_result.computed_checksum = n_csum;
    assign o_result.offending_byte    = offend;
    assign o_result.relay_valid       = !i_mode && i_cfg.relay_enable;
    assign o_result.relay_data        = (!i_mode && i_cfg.relay_enable) ? i_rx_byte : 8'd0;

`ifndef SYNTHESIS
    a_count_below_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == xcpd_pkg::ST_DATA |-> r_count < r_length)
        else $error("payload count reached length inside payload phase");
`endif

endmodule

// File: src/xor_checked_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// xor_checked_packet_deframer_core
// Byte stream deframer with xor checksum, payload buffer and relay echo.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one request per byte: in
// mode 0 a received link byte is fed to the frame parser, in mode 1 the
// payload buffer is read at i_read_index (0 beyond the buffer). Output
// channel (o_out_valid / i_out_stall) returns exactly one result per request
// with the event code, the frame's type, length and running checksum, the
// offending byte, the relay echo and the read data.
// Throughput is one request per cycle while o_in_stall is low; a request
// passes the stage behind the parser (ram read), then the output register.
// A stage behind the parser and an output register decouple the two sides:
// while the output waits under stall a further request is still taken, and
// o_in_stall rises only when both are full.
// Reset (synchronous) returns the parser to header search, clears the frame
// fields and sets relay_enable to 0 and max_length to 201. The payload ram
// is not cleared; an entry never written reads as an unknown value.
// Registers: relay_enable at byte address 0, max_length at byte address 4.
// ----------------------------------------------------------------------------
module xor_checked_packet_deframer_core #(
    parameter int BUFFER_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_read_index,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_frame_type,
    output logic [7:0]  o_packet_length,
    output logic [7:0]  o_computed_checksum,
    output logic [7:0]  o_offending_byte,
    output logic        o_relay_valid,
    output logic [7:0]  o_relay_data,
    output logic [7:0]  o_read_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    xcpd_pkg::t_cfg    r_cfg;
    xcpd_pkg::t_result parse_result;
    xcpd_pkg::t_wr_req wr_req;
    logic [AW-1:0]     wr_addr;

    logic              accept;
    logic              s1_move;
    logic              out_take;
    logic              rd_oob;
    logic              ram_en;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_rdata;

    logic              r_s1_valid;
    xcpd_pkg::t_result r_s1_result;
    logic              r_s1_read;
    logic              r_s1_oob;

    logic              r_out_valid;
    xcpd_pkg::t_result r_out_result;
    logic [7:0]        r_out_read_data;

    // configuration
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.relay_enable <= 1'b0;
            r_cfg.max_length   <= xcpd_pkg::C_MAX_LENGTH_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                xcpd_pkg::REG_RELAY_ENABLE: r_cfg.relay_enable <= pwdata[0];
                xcpd_pkg::REG_MAX_LENGTH:   r_cfg.max_length   <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            xcpd_pkg::REG_RELAY_ENABLE: prdata = {31'd0, r_cfg.relay_enable};
            xcpd_pkg::REG_MAX_LENGTH:   prdata = {24'd0, r_cfg.max_length};
            default:                    prdata = 32'd0;
        endcase
    end

    // handshake
    assign out_take   = r_out_valid && !i_out_stall;
    assign s1_move    = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_move;
    assign accept     = i_in_valid && !o_in_stall;

    xcpd_parser #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_mode    (i_mode),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (r_cfg),
        .o_result  (parse_result),
        .o_wr_req  (wr_req),
        .o_wr_addr (wr_addr)
    );

    // at most one ram access per request, so a write and a read never share a cycle
    assign rd_oob   = {1'b0, i_read_index} >= 9'(BUFFER_DEPTH);
    assign ram_en   = (accept && i_mode) || wr_req.en;
    assign ram_addr = i_mode ? i_read_index[AW-1:0] : wr_addr;

    xcpd_ram #(
        .WIDTH(8),
        .DEPTH(BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (wr_req.en),
        .i_addr  (ram_addr),
        .i_wdata (wr_req.data),
        .o_rdata (ram_rdata)
    );

    // stage behind the parser, waits for the ram read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_result <= parse_result;
            r_s1_read   <= i_mode;
            r_s1_oob    <= rd_oob;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_result    <= r_s1_result;
            r_out_read_data <= (r_s1_read && !r_s1_oob) ? ram_rdata : 8'd0;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_event_res         = r_out_result.event_res;
    assign o_frame_type        = r_out_result.frame_type;
    assign o_packet_length     = r_out_result.packet_length;
    assign o_computed_checksum = r_out_result.computed_checksum;
    assign o_offending_byte    = r_out_result.offending_byte;
    assign o_relay_valid       = r_out_result.relay_valid;
    assign o_relay_data        = r_out_result.relay_data;
    assign o_read_data         = r_out_read_data;

`ifndef SYNTHESIS
    a_s1_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !(r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("pending request did not reach the output register");

    a_read_has_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_data != 8'd0 |->
            o_event_res == xcpd_pkg::EV_NONE && !o_relay_valid)
        else $error("buffer read result carries a parser event");

    a_offend_only_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_offending_byte != 8'd0 |->
            o_event_res == xcpd_pkg::EV_CHECK || o_event_res == xcpd_pkg::EV_CR ||
            o_event_res == xcpd_pkg::EV_LF)
        else $error("offending byte reported without an error event");
`endif

endmodule
